[src/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define IRW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irw_checker: same-cycle implication failed");

// Next-cycle implication, switched off while reset is high.
`define IRW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irw_checker: next-cycle implication failed");

`endif

[src/irw_pkg.sv]
// Shared types and constants of the improvement rate window.
// Used by every module of the block but irw_ram; depends on nothing.
`timescale 1ns / 1ps

package irw_pkg;

  // Field widths.
  localparam int TIME_W      = 48;
  localparam int SCORE_W     = 47;
  localparam int RATIO_W     = 17;
  localparam int FRAC_W      = 16;
  localparam int QUOT_W      = 32;
  localparam int PROD_W      = SCORE_W + RATIO_W;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 1;

  localparam int DEFAULT_HISTORY_DEPTH = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_TIMEOUT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RATIO = 1'b1;

  // Ratio constants in Q1.16.
  localparam logic [RATIO_W-1:0] RATIO_ONE   = 17'h10000;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 17'h08000;

  // Request carried on the input channel.
  typedef struct packed {
    logic        [TIME_W-1:0] sample_time;
    logic signed [TIME_W-1:0] sample_score;
  } sample_t;

  // Result carried on the output channel.
  typedef struct packed {
    logic [QUOT_W-1:0] slowness;
    logic              zero_base;
    logic              history_dropped;
  } result_t;

  // One history record as held in the record memory.
  typedef struct packed {
    logic [TIME_W-1:0]  rec_time;
    logic [SCORE_W-1:0] rec_score;
  } record_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;
    logic capture;
    logic restart;
    logic append;
    logic mul;
    logic pop;
    logic head_load;
    logic diff_load;
    logic div_init;
    logic div_step;
    logic res_zero;
    logic res_max;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic backward;
    logic newer;
    logic window;
    logic pop_more;
    logic head_zero;
    logic head_late;
    logic overflow;
    logic div_last;
  } ctrl_sts_t;

endpackage

[src/irw_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds no reset and no initial contents.
`timescale 1ns / 1ps

module irw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/irw_ctrl.sv]
// Controller of the improvement rate window: sequences one request at a time.
// Depends on irw_pkg for the command and status structs.
`timescale 1ns / 1ps

module irw_ctrl import irw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_APPEND   = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_POP_RD   = 4'd5;
  localparam logic [3:0] S_POP_CHK  = 4'd6;
  localparam logic [3:0] S_DIV_PREP = 4'd7;
  localparam logic [3:0] S_DIV_CHK  = 4'd8;
  localparam logic [3:0] S_DIV      = 4'd9;
  localparam logic [3:0] S_FINISH   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // Only the idle state takes a new request.
  assign in_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.restart = sts.backward;
        state_next  = S_APPEND;
      end
      S_APPEND: begin
        cmd.append = sts.newer;
        if (sts.window) begin
          state_next = S_MUL;
        end else begin
          cmd.res_zero = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_POP_RD;
      end
      S_POP_RD: begin
        // The registered memory read of the front record is under way; S_POP_CHK sees it.
        state_next = S_POP_CHK;
      end
      S_POP_CHK: begin
        if (sts.pop_more) begin
          cmd.pop    = 1'b1;
          state_next = S_POP_RD;
        end else begin
          cmd.head_load = 1'b1;
          state_next    = S_DIV_PREP;
        end
      end
      S_DIV_PREP: begin
        cmd.diff_load = 1'b1;
        if (sts.head_zero) begin
          cmd.res_max = 1'b1;
          state_next  = S_FINISH;
        end else if (sts.head_late) begin
          cmd.res_zero = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_DIV_CHK;
        end
      end
      S_DIV_CHK: begin
        if (sts.overflow) begin
          cmd.res_max = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // Wait until the output register is free.
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[src/irw_datapath.sv]
// Datapath of the improvement rate window: record queue, multiplier, divider.
// Depends on irw_pkg and instantiates irw_ram for the record history.
`timescale 1ns / 1ps

module irw_datapath import irw_pkg::*; #(
  parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output ctrl_sts_t              sts,
  input  sample_t                in_data,
  output result_t                out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W     = $clog2(HISTORY_DEPTH);
  localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int REC_W     = $bits(record_t);
  localparam int DIV_CNT_W = $clog2(QUOT_W);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);

  // Configuration registers.
  logic [TIME_W-1:0]  min_timeout;
  logic [RATIO_W-1:0] window_ratio;

  // Current request and queue bookkeeping.
  logic [TIME_W-1:0]  cur_time;
  logic [SCORE_W-1:0] cur_score;
  logic [TIME_W-1:0]  last_time;
  logic [SCORE_W-1:0] last_score;
  logic [IDX_W-1:0]   front;
  logic [IDX_W-1:0]   back;
  logic [CNT_W-1:0]   count;
  logic               dropped;

  // Window head and divider.
  logic [SCORE_W-1:0]   head_score;
  logic [TIME_W-1:0]    win_time;
  logic [TIME_W-1:0]    diff;
  logic [TIME_W-1:0]    rem;
  logic [QUOT_W-1:0]    num_low;
  logic [QUOT_W-1:0]    quot;
  logic                 zero_base;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Combinational helpers.
  logic [RATIO_W-1:0] ratio_eff;
  logic [PROD_W-1:0]  product;
  logic               queue_full;
  logic [IDX_W-1:0]   back_inc;
  logic [IDX_W-1:0]   front_inc;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  record_t            wr_rec;
  logic [REC_W-1:0]   rd_data;
  record_t            rd_rec;
  logic [TIME_W:0]    shifted;
  logic [TIME_W:0]    div_diff;
  logic               div_ge;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    if (idx == IDX_LAST) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

  assign back_inc   = wrap_inc(back);
  assign front_inc  = wrap_inc(front);
  assign queue_full = (count == CNT_FULL);

  // Ratios above one act as one.
  assign ratio_eff = (window_ratio > RATIO_ONE) ? RATIO_ONE : window_ratio;
  assign product   = cur_score * ratio_eff;

  // One quotient bit per step of the restoring divider.
  assign shifted  = {rem, num_low[QUOT_W-1]};
  assign div_ge   = (shifted >= {1'b0, win_time});
  assign div_diff = shifted - {1'b0, win_time};

  // Record memory write selection.
  always_comb begin
    wr_en   = cmd.init_wr | cmd.restart | cmd.append;
    wr_addr = '0;
    wr_rec  = '0;
    if (cmd.restart) begin
      wr_rec.rec_time = TIME_W'(1);
    end else if (cmd.append) begin
      wr_addr = back_inc;
      wr_rec  = '{rec_time: cur_time, rec_score: cur_score};
    end
  end

  irw_ram #(
    .WIDTH (REC_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (REC_W'(wr_rec)),
    .rd_addr (front),
    .rd_data (rd_data)
  );

  assign rd_rec = record_t'(rd_data);

  // Status towards the controller.
  always_comb begin
    sts.backward  = (last_time > cur_time);
    sts.newer     = (last_score < cur_score);
    sts.window    = (cur_time >= min_timeout) && (cur_score != '0);
    sts.pop_more  = (count > CNT_W'(1)) && (rd_rec.rec_score < head_score);
    sts.head_zero = (win_time == '0);
    sts.head_late = (cur_time <= win_time);
    sts.overflow  = ({{FRAC_W{1'b0}}, diff[TIME_W-1:FRAC_W]} >= win_time);
    sts.div_last  = (div_cnt == DIV_CNT_W'(QUOT_W - 1));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_timeout  <= '0;
      window_ratio <= RATIO_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_TIMEOUT:  min_timeout  <= cfg_data[TIME_W-1:0];
        REG_WINDOW_RATIO: window_ratio <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Queue pointers and newest record; the queue starts as one record (0,0).
  always_ff @(posedge clk) begin
    if (rst) begin
      front      <= '0;
      back       <= '0;
      count      <= CNT_W'(1);
      last_time  <= '0;
      last_score <= '0;
    end else if (cmd.restart) begin
      front      <= '0;
      back       <= '0;
      count      <= CNT_W'(1);
      last_time  <= TIME_W'(1);
      last_score <= '0;
    end else if (cmd.append) begin
      back       <= back_inc;
      last_time  <= cur_time;
      last_score <= cur_score;
      if (queue_full) begin
        front <= front_inc;
      end else begin
        count <= count + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      front <= front_inc;
      count <= count - CNT_W'(1);
    end
  end

  // Request capture and drop flag; negative scores clamp to zero.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_time  <= in_data.sample_time;
      cur_score <= in_data.sample_score[TIME_W-1] ? '0 : in_data.sample_score[SCORE_W-1:0];
      dropped   <= 1'b0;
    end else if (cmd.append) begin
      dropped <= queue_full;
    end
  end

  // Window threshold, head record and elapsed time.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      head_score <= product[FRAC_W +: SCORE_W];
    end
    if (cmd.head_load) begin
      win_time <= rd_rec.rec_time;
    end
    if (cmd.diff_load) begin
      diff <= cur_time - win_time;
    end
  end

  // Divider and result value.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= {{FRAC_W{1'b0}}, diff[TIME_W-1:FRAC_W]};
      num_low <= {diff[FRAC_W-1:0], {(QUOT_W - FRAC_W){1'b0}}};
      quot    <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= div_ge ? div_diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      num_low <= {num_low[QUOT_W-2:0], 1'b0};
      quot    <= {quot[QUOT_W-2:0], div_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end else if (cmd.res_zero) begin
      quot <= '0;
    end else if (cmd.res_max) begin
      quot <= '1;
    end
    if (cmd.res_zero || cmd.div_init) begin
      zero_base <= 1'b0;
    end else if (cmd.res_max) begin
      zero_base <= (win_time == '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= '{slowness: quot, zero_base: zero_base, history_dropped: dropped};
    end
  end

endmodule

[src/improvement_rate_window.sv]
// Improvement rate window, top level.
// Requests on the input channel carry a timestamp and a score; each gives exactly
// one result on the output channel with the Q16.16 slowness and two flags.
// Both channels use valid and stall: a request moves at a clock edge with valid
// high and stall low. The block works on one request at a time; in_stall is low
// only while it is idle, and a finished result waits in the output register, so
// a new request is taken while the receiver still stalls the previous result.
// When the timeout has not passed or the score is zero the result is zero.
// Otherwise up to HISTORY_DEPTH - 1 front records are popped; the result is
// saturated when the head time is zero or the quotient overflows, zero when the
// head time is not before the sample, and else the divider's quotient. Each
// front-record check waits on the registered memory read, and the divider yields
// one quotient bit per cycle for all 32 bits. The next request is taken in the
// cycle the result appears. If the output register is still held by a stalled
// result, the block waits for it before loading the next one.
// Synchronous reset returns the queue to the single record (0,0) and the
// configuration registers to their defaults; after reset the S_INIT state writes
// memory entry zero, with in_stall high. Configuration writes are taken at any time.
`timescale 1ns / 1ps

module improvement_rate_window import irw_pkg::*; #(
  parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sample_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output result_t                out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  irw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Queue, arithmetic and output register.
  irw_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[src/irw_checker.sv]
// Port-level checker of the improvement rate window and its bind statement.
// Depends on irw_pkg and on the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irw_checker import irw_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data
);

  // A stalled result stays offered.
  `IRW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // The block works on one request at a time.
  `IRW_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // No result can appear in the cycle right after a request is taken.
  `IRW_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && !in_stall, !$rose(out_valid))

  // A zero head time always comes with a saturated slowness.
  `IRW_ASSERT_IMPL(a_zero_base_sat, clk, rst, out_valid && out_data.zero_base, out_data.slowness == '1)

  // The memory initialisation cycle after reset takes no request.
  `IRW_ASSERT_IMPL(a_init_after_reset, clk, rst, $past(rst), in_stall)

endmodule

bind improvement_rate_window irw_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
